// ===== rtl/tdr_pkg.sv =====
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared types and constants for the twin diff dirty region scan.
// ----------------------------------------------------------------------------
package tdr_pkg;

	// configuration register indexes
	localparam logic REG_MERGE_THRESHOLD = 1'b0;
	localparam logic REG_BLOCK_SIZE      = 1'b1;

	// register reset values
	localparam logic [15:0] MERGE_THRESHOLD_RESET = 16'd64;
	localparam logic [31:0] BLOCK_SIZE_RESET      = 32'd1;

	// threshold forced on large blocks
	localparam logic [31:0] BIG_BLOCK_BYTES = 32'd4194304;
	localparam logic [15:0] BIG_THRESHOLD   = 16'd256;

	// bytes in one full word
	localparam logic [3:0] WORD_BYTES = 4'd8;

	// result kinds
	localparam logic KIND_REGION  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// one input item
	typedef struct packed {
		logic [63:0] working_word;
		logic [63:0] twin_word;
		logic [3:0]  valid_bytes;
		logic        last_word;
	} tdr_item_t;

	// up to three results caused by one item, in delivery order
	typedef struct packed {
		logic        close_v;
		logic        part_v;
		logic        sum_v;
		logic [31:0] close_off;
		logic [31:0] close_len;
		logic [31:0] part_off;
		logic [3:0]  part_len;
		logic [31:0] sum_total;
		logic [29:0] sum_count;
	} tdr_bundle_t;

endpackage

// ===== rtl/tdr_core.sv =====
// ----------------------------------------------------------------------------
// tdr_core
// Word compare and running scan state; forms the results of one item.
// ----------------------------------------------------------------------------
module tdr_core import tdr_pkg::*; #(
	parameter int OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  tdr_item_t   item,
	input  logic [15:0] merge_threshold,
	input  logic [31:0] block_size_bytes,
	output tdr_bundle_t bundle
);

	logic [28:0]            word_index_q;
	logic [OFFSET_BITS-1:0] run_start_q;
	logic [OFFSET_BITS-1:0] run_end_q;
	logic [16:0]            clean_gap_q;
	logic                   run_open_q;
	logic [31:0]            bytes_sum_q;
	logic [29:0]            regions_sum_q;

	logic [3:0]             vb_sat;
	logic                   full;
	logic                   word_diff;
	logic                   dirty_full;
	logic                   clean_full;
	logic [15:0]            thr;
	logic [31:0]            off_full;
	logic [31:0]            end_full;
	logic [28:0]            index_inc;
	logic [OFFSET_BITS-1:0] off;
	logic [OFFSET_BITS-1:0] start_u;
	logic [OFFSET_BITS-1:0] end_u;
	logic                   open_u;
	logic [16:0]            gap_inc;
	logic                   gap_over;
	logic                   close;
	logic [OFFSET_BITS-1:0] close_len;
	logic [7:0]             byte_diff;
	logic [7:0]             byte_valid;
	logic                   part_emit;
	logic [31:0]            sum_close;
	logic [31:0]            sum_next;
	logic [29:0]            count_next;

	// saturate byte count, pick the threshold
	assign vb_sat = (item.valid_bytes > WORD_BYTES) ? WORD_BYTES : item.valid_bytes;
	assign full   = (vb_sat == WORD_BYTES);
	assign thr    = (block_size_bytes > BIG_BLOCK_BYTES) ? BIG_THRESHOLD : merge_threshold;

	// word offsets
	assign index_inc = word_index_q + 29'd1;
	assign off_full  = {word_index_q, 3'b000};
	assign end_full  = {index_inc, 3'b000};
	assign off       = off_full[OFFSET_BITS-1:0];

	// full word compare
	assign word_diff  = (item.working_word != item.twin_word);
	assign dirty_full = full && word_diff;
	assign clean_full = full && !word_diff;

	// run bounds after this word
	assign start_u = (dirty_full && !run_open_q) ? off : run_start_q;
	assign end_u   = dirty_full ? end_full[OFFSET_BITS-1:0] : run_end_q;
	assign open_u  = run_open_q || dirty_full;

	// trailing clean gap
	assign gap_inc  = clean_gap_q + 17'd8;
	assign gap_over = clean_full && run_open_q && (gap_inc > {1'b0, thr});

	// run closes on a long gap, a remainder word or the end of block
	assign close     = open_u && (gap_over || !full || item.last_word);
	assign close_len = end_u - start_u;

	// per-byte compare of a remainder word
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			byte_diff[i]  = (item.working_word[8*i +: 8] != item.twin_word[8*i +: 8]);
			byte_valid[i] = (4'(i) < vb_sat);
		end
	end
	assign part_emit = !full && ((byte_diff & byte_valid) != 8'd0);

	// running totals
	assign sum_close  = bytes_sum_q + (close ? 32'(close_len) : 32'd0);
	assign sum_next   = sum_close + (part_emit ? {28'd0, vb_sat} : 32'd0);
	assign count_next = regions_sum_q + {29'd0, close} + {29'd0, part_emit};

	// result bundle
	always_comb begin
		bundle.close_v   = close;
		bundle.part_v    = part_emit;
		bundle.sum_v     = item.last_word;
		bundle.close_off = 32'(start_u);
		bundle.close_len = 32'(close_len);
		bundle.part_off  = 32'(off);
		bundle.part_len  = vb_sat;
		bundle.sum_total = sum_next;
		bundle.sum_count = count_next;
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_index_q  <= '0;
			run_start_q   <= '0;
			run_end_q     <= '0;
			clean_gap_q   <= '0;
			run_open_q    <= 1'b0;
			bytes_sum_q   <= '0;
			regions_sum_q <= '0;
		end else if (advance) begin
			if (item.last_word) begin
				word_index_q  <= '0;
				run_start_q   <= '0;
				run_end_q     <= '0;
				clean_gap_q   <= '0;
				run_open_q    <= 1'b0;
				bytes_sum_q   <= '0;
				regions_sum_q <= '0;
			end else begin
				word_index_q  <= index_inc;
				run_start_q   <= start_u;
				run_end_q     <= end_u;
				run_open_q    <= open_u && !close;
				bytes_sum_q   <= sum_next;
				regions_sum_q <= count_next;
				if (close || dirty_full) begin
					clean_gap_q <= '0;
				end else if (clean_full && run_open_q) begin
					clean_gap_q <= gap_inc;
				end
			end
		end
	end

endmodule

// ===== rtl/tdr_outq.sv =====
// ----------------------------------------------------------------------------
// tdr_outq
// Result register holding the results of one item; hands them out in order.
// ----------------------------------------------------------------------------
module tdr_outq import tdr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  tdr_bundle_t  bundle,
	output logic         can_load,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // region_offset, region_length, total_bytes, region_count
	output logic [0:0]   m_tuser,  // result_kind
	output logic         m_tlast   // last_result
);

	logic        close_v_q;
	logic        part_v_q;
	logic        sum_v_q;
	logic [31:0] close_off_q;
	logic [31:0] close_len_q;
	logic [31:0] part_off_q;
	logic [3:0]  part_len_q;
	logic [31:0] sum_total_q;
	logic [29:0] sum_count_q;

	logic        pop;
	logic        close_v_p;
	logic        part_v_p;
	logic        sum_v_p;
	logic        kind;
	logic [31:0] o_off;
	logic [31:0] o_len;
	logic [31:0] o_total;
	logic [29:0] o_count;

	// drop the front slot when taken
	assign m_tvalid = close_v_q || part_v_q || sum_v_q;
	assign pop      = m_tvalid && m_tready;

	always_comb begin
		close_v_p = close_v_q;
		part_v_p  = part_v_q;
		sum_v_p   = sum_v_q;
		if (pop) begin
			priority if (close_v_q) begin
				close_v_p = 1'b0;
			end else if (part_v_q) begin
				part_v_p = 1'b0;
			end else begin
				sum_v_p = 1'b0;
			end
		end
	end

	assign can_load = !(close_v_p || part_v_p || sum_v_p);

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_v_q <= 1'b0;
			part_v_q  <= 1'b0;
			sum_v_q   <= 1'b0;
		end else if (load) begin
			close_v_q <= bundle.close_v;
			part_v_q  <= bundle.part_v;
			sum_v_q   <= bundle.sum_v;
		end else begin
			close_v_q <= close_v_p;
			part_v_q  <= part_v_p;
			sum_v_q   <= sum_v_p;
		end
	end

	// slot payloads
	always_ff @(posedge clk) begin
		if (load) begin
			close_off_q <= bundle.close_off;
			close_len_q <= bundle.close_len;
			part_off_q  <= bundle.part_off;
			part_len_q  <= bundle.part_len;
			sum_total_q <= bundle.sum_total;
			sum_count_q <= bundle.sum_count;
		end
	end

	// front slot to the output
	always_comb begin
		priority if (close_v_q) begin
			kind    = KIND_REGION;
			o_off   = close_off_q;
			o_len   = close_len_q;
			o_total = 32'd0;
			o_count = 30'd0;
		end else if (part_v_q) begin
			kind    = KIND_REGION;
			o_off   = part_off_q;
			o_len   = {28'd0, part_len_q};
			o_total = 32'd0;
			o_count = 30'd0;
		end else begin
			kind    = KIND_SUMMARY;
			o_off   = 32'd0;
			o_len   = 32'd0;
			o_total = sum_total_q;
			o_count = sum_count_q;
		end
	end

	assign m_tdata = {2'b00, o_count, o_total, o_len, o_off};
	assign m_tuser = kind;
	assign m_tlast = (kind == KIND_SUMMARY);

endmodule

// ===== rtl/twin_diff_dirty_region_scan.sv =====
// The first result of an item is offered from the result register, which loads it from the input register once free.
// Throughput: one item per cycle while each item causes at most one result and the receiver takes it;
//   an item causing several results holds the result register until all of them are taken.
// The result register, one slot each for a closed region, a partial region and a summary, sets the output rate.
// Reset: arst_n clears the scan state and sets merge_threshold 64, block size 1.
// ----------------------------------------------------------------------------
// twin_diff_dirty_region_scan
// Compares working and twin words and streams out dirty regions and a summary.
// ----------------------------------------------------------------------------
module twin_diff_dirty_region_scan import tdr_pkg::*; #(
	parameter int OFFSET_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,  // working_word, twin_word, valid_bytes, zero pad
	input  logic         s_tlast,  // last_word
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // region_offset, region_length, total_bytes, region_count
	output logic [0:0]   m_tuser,  // result_kind
	output logic         m_tlast   // last_result
);

	logic [15:0] merge_threshold_q;
	logic [31:0] block_size_q;

	tdr_item_t   item_s1;
	logic        valid_s1;
	logic        advance;
	logic        can_load;
	tdr_bundle_t bundle;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_threshold_q <= MERGE_THRESHOLD_RESET;
			block_size_q      <= BLOCK_SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MERGE_THRESHOLD: merge_threshold_q <= cfg_wdata[15:0];
				REG_BLOCK_SIZE:      block_size_q      <= cfg_wdata;
			endcase
		end
	end

	// input register
	assign advance  = valid_s1 && can_load;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.working_word <= s_tdata[63:0];
			item_s1.twin_word    <= s_tdata[127:64];
			item_s1.valid_bytes  <= s_tdata[131:128];
			item_s1.last_word    <= s_tlast;
		end
	end

	// compare and scan state
	tdr_core #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (advance),
		.item             (item_s1),
		.merge_threshold  (merge_threshold_q),
		.block_size_bytes (block_size_q),
		.bundle           (bundle)
	);

	// result register and output order
	tdr_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.bundle   (bundle),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef NO_ASSERTIONS
	// a held item is not dropped while the result register is busy
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input register lost a stalled item");

	// only the summary closes a scan
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == KIND_SUMMARY)))
		else $error("last flag and result kind disagree");

	// region records carry no totals, summaries carry no region
	a_region_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_REGION) |-> (m_tdata[127:64] == 64'd0))
		else $error("region record carries summary fields");

	a_summary_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_SUMMARY) |-> (m_tdata[63:0] == 64'd0))
		else $error("summary carries region fields");
`endif

endmodule

// ===== tb/twin_diff_dirty_region_scan_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twin_diff_dirty_region_scan_tb
// Streams word pairs through the dirty region scanner under random stalls on
// both sides, predicts every region record and scan summary in a scoreboard,
// and checks each result as it leaves the block.
// ----------------------------------------------------------------------------
module twin_diff_dirty_region_scan_tb;
	import tdr_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 10;

	// one result item as seen on the output stream
	typedef struct {
		logic        kind;
		logic [31:0] offset;
		logic [31:0] length;
		logic [31:0] total;
		logic [29:0] count;
		logic        last;
	} scan_record_t;

	// receiver stall patterns
	typedef enum int {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_t;

	// predicts the scanner and checks its results in order
	class region_tracker;
		logic [15:0]  merge_thr;
		logic [31:0]  block_size;
		logic [28:0]  word_idx;
		logic [31:0]  run_start;
		logic [31:0]  run_end;
		logic [31:0]  clean_gap;
		bit           run_open;
		logic [31:0]  bytes_sum;
		logic [29:0]  regions_sum;
		scan_record_t pending[$];
		int unsigned  errors;

		function new();
			merge_thr  = MERGE_THRESHOLD_RESET;
			block_size = BLOCK_SIZE_RESET;
			errors     = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			word_idx    = '0;
			run_start   = '0;
			run_end     = '0;
			clean_gap   = '0;
			run_open    = 0;
			bytes_sum   = '0;
			regions_sum = '0;
		endfunction

		function void write_reg(logic idx, logic [31:0] value);
			if (idx == REG_MERGE_THRESHOLD) begin
				merge_thr = value[15:0];
			end else begin
				block_size = value;
			end
		endfunction

		// large blocks force the fixed threshold
		function logic [31:0] eff_threshold();
			if (block_size > BIG_BLOCK_BYTES) begin
				return 32'(BIG_THRESHOLD);
			end
			return {16'h0, merge_thr};
		endfunction

		function void emit_region(logic [31:0] off, logic [31:0] len);
			scan_record_t r;
			bytes_sum   = bytes_sum + len;
			regions_sum = regions_sum + 30'd1;
			r.kind   = KIND_REGION;
			r.offset = off;
			r.length = len;
			r.total  = '0;
			r.count  = '0;
			r.last   = 1'b0;
			pending.push_back(r);
		endfunction

		function void close_run();
			if (run_open) begin
				emit_region(run_start, run_end - run_start);
				run_open  = 0;
				clean_gap = '0;
			end
		endfunction

		// note an accepted word pair and queue the results it causes
		function void note_word(tdr_item_t it);
			logic [3:0]   vb;
			logic [31:0]  off;
			logic [31:0]  thr;
			logic [63:0]  mask;
			scan_record_t r;
			vb  = (it.valid_bytes > WORD_BYTES) ? WORD_BYTES : it.valid_bytes;
			off = {word_idx, 3'b000};
			thr = eff_threshold();
			if (vb == WORD_BYTES) begin
				if (it.working_word != it.twin_word) begin
					if (!run_open) begin
						run_start = off;
						run_open  = 1;
					end
					clean_gap = '0;
					run_end   = (32'(word_idx) + 32'd1) << 3;
				end else if (run_open) begin
					clean_gap = clean_gap + 32'd8;
					if (clean_gap > thr) close_run();
				end
			end else begin
				// remainder word: only its low bytes count
				mask = (vb == 4'd0) ? 64'h0 : (~64'h0 >> (64 - 8 * int'(vb)));
				close_run();
				if (((it.working_word ^ it.twin_word) & mask) != 64'h0) begin
					emit_region(off, {28'h0, vb});
				end
			end
			word_idx = word_idx + 29'd1;
			if (it.last_word) begin
				close_run();
				r.kind   = KIND_SUMMARY;
				r.offset = '0;
				r.length = '0;
				r.total  = bytes_sum;
				r.count  = regions_sum;
				r.last   = 1'b1;
				pending.push_back(r);
				clear_scan();
			end
		endfunction

		// compare one output item with the oldest prediction
		function void check_record(scan_record_t got);
			scan_record_t want;
			if (pending.size() == 0) begin
				$error("unexpected result kind %0h offset %0h length %0h",
					got.kind, got.offset, got.length);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind) begin
				$error("result_kind expected %0h actual %0h", want.kind, got.kind);
				errors++;
			end
			if (got.offset !== want.offset) begin
				$error("region_offset expected %0h actual %0h", want.offset, got.offset);
				errors++;
			end
			if (got.length !== want.length) begin
				$error("region_length expected %0h actual %0h", want.length, got.length);
				errors++;
			end
			if (got.total !== want.total) begin
				$error("total_bytes expected %0h actual %0h", want.total, got.total);
				errors++;
			end
			if (got.count !== want.count) begin
				$error("region_count expected %0h actual %0h", want.count, got.count);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last_result expected %0h actual %0h", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic         cfg_index;
	logic [31:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;  // working_word, twin_word, valid_bytes, zero pad
	logic         s_tlast;  // last_word
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;  // region_offset, region_length, total_bytes, region_count
	logic [0:0]   m_tuser;  // result_kind
	logic         m_tlast;  // last_result

	region_tracker tracker;
	int unsigned   cycles;
	int unsigned   items_sent;
	int            burst_left;
	bit            steady;
	rx_mode_t      rx_mode;
	int            rx_count;
	int            rx_hold;
	bit            rx_state;

	twin_diff_dirty_region_scan DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("twin_diff_dirty_region_scan_tb: errors");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		scan_record_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind   = m_tuser[0];
			got.offset = m_tdata[31:0];
			got.length = m_tdata[63:32];
			got.total  = m_tdata[95:64];
			got.count  = m_tdata[125:96];
			got.last   = m_tlast;
			tracker.check_record(got);
		end
	end

	// receiver stall pattern, switched at random among open, coin-flip and bursty modes
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_count == 0) begin
				rx_mode  = rx_mode_t'($urandom_range(2, 0));
				rx_count = $urandom_range(100, 20);
			end
			rx_count--;
			case (rx_mode)
				RX_OPEN: begin
					m_tready <= 1'b1;
				end
				RX_COIN: begin
					m_tready <= 1'($urandom_range(1, 0));
				end
				default: begin
					if (rx_hold <= 0) begin
						rx_state = ~rx_state;
						rx_hold  = rx_state ? $urandom_range(5, 1) : $urandom_range(20, 1);
					end
					rx_hold--;
					m_tready <= rx_state;
				end
			endcase
		end
	end

	function automatic tdr_item_t item_of(logic [63:0] w, logic [63:0] t,
		logic [3:0] vb, logic last);
		tdr_item_t it;
		it.working_word = w;
		it.twin_word    = t;
		it.valid_bytes  = vb;
		it.last_word    = last;
		return it;
	endfunction

	// random word pair; junk flips bytes past the valid ones
	function automatic tdr_item_t make_word(bit dirty, logic [3:0] vb, bit last, bit junk);
		int          nv;
		int          b;
		int          i;
		logic [63:0] w;
		logic [63:0] diff;
		nv   = (vb > 8) ? 8 : int'(vb);
		w    = {$urandom, $urandom};
		diff = '0;
		if (dirty && nv > 0) begin
			if ($urandom_range(7, 0) == 0) begin
				diff = {$urandom, $urandom} | 64'h1;
				if (nv < 8) diff = diff & (~64'h0 >> (64 - 8 * nv));
			end else begin
				b = $urandom_range(nv - 1, 0);
				diff[8 * b +: 8] = 8'($urandom_range(255, 1));
			end
		end
		if (junk) begin
			for (i = nv; i < 8; i++) diff[8 * i +: 8] = 8'($urandom_range(255, 1));
		end
		return item_of(w, w ^ diff, vb, last);
	endfunction

	// sender bursts with random gaps
	task automatic pace();
		int gap;
		if (steady) return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(16, 0);
		gap = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 1) : $urandom_range(4, 1);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (gap - 1) @(negedge clk);
	endtask

	task automatic send_word(tdr_item_t it);
		pace();
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {4'h0, it.valid_bytes, it.twin_word, it.working_word};
		s_tlast  <= it.last_word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_word(it);
		items_sent++;
	endtask

	// hold off the sender until every result is out and the pipe is empty
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		tracker.write_reg(idx, value);
	endtask

	// one block: dirty and clean streaks, some odd words, then a final word
	task automatic run_scan(int n_words, int gap_span);
		int       i;
		int       streak;
		int       pick;
		bit       dirty_mode;
		logic [3:0] vb;
		streak     = 0;
		dirty_mode = 1'b1;
		for (i = 0; i < n_words - 1; i++) begin
			if (streak == 0) begin
				dirty_mode = ~dirty_mode;
				streak = dirty_mode ? $urandom_range(4, 1) : $urandom_range(gap_span, 1);
			end
			streak--;
			if ($urandom_range(19, 0) == 0) begin
				send_word(make_word(1'($urandom_range(1, 0)), 4'($urandom_range(15, 0)),
					1'b0, 1'($urandom_range(1, 0))));
			end else begin
				send_word(make_word(dirty_mode, WORD_BYTES, 1'b0, 1'b0));
			end
		end
		pick = $urandom_range(9, 0);
		if (pick < 5) vb = WORD_BYTES;
		else if (pick < 8) vb = 4'($urandom_range(7, 1));
		else if (pick == 8) vb = 4'd0;
		else vb = 4'($urandom_range(15, 9));
		send_word(make_word(1'($urandom_range(1, 0)), vb, 1'b1, 1'($urandom_range(1, 0))));
	endtask

	task automatic run_phase(logic [15:0] thr, logic [31:0] bsize, int items, bit no_idle);
		int span;
		int start;
		settle();
		write_reg(REG_MERGE_THRESHOLD, {16'h0, thr});
		write_reg(REG_BLOCK_SIZE, bsize);
		steady = no_idle;
		span   = int'(tracker.eff_threshold() / 8) + 2;
		if (span > 40) span = 40;
		start  = items_sent;
		while (items_sent - start < items) begin
			if ($urandom_range(4, 0) == 0) run_scan($urandom_range(30, 13), span);
			else run_scan($urandom_range(12, 1), span);
		end
	endtask

	initial begin
		tracker    = new();
		cycles     = 0;
		items_sent = 0;
		burst_left = 0;
		steady     = 1'b0;
		rx_mode    = RX_OPEN;
		rx_count   = 0;
		rx_hold    = 0;
		rx_state   = 1'b0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_MERGE_THRESHOLD;
		cfg_wdata  = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		m_tready   = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: a clean gap equal to the threshold stays merged
		send_word(item_of(~64'h0, 64'h0, WORD_BYTES, 1'b0));
		repeat (8) send_word(make_word(1'b0, WORD_BYTES, 1'b0, 1'b0));
		send_word(item_of(64'h0, ~64'h0, WORD_BYTES, 1'b0));
		send_word(make_word(1'b0, WORD_BYTES, 1'b1, 1'b0));

		// small threshold: merge, close, remainders, saturation, end of block
		settle();
		write_reg(REG_MERGE_THRESHOLD, 32'd8);
		send_word(make_word(1'b1, WORD_BYTES, 1'b0, 1'b0));
		send_word(make_word(1'b0, WORD_BYTES, 1'b0, 1'b0));
		send_word(make_word(1'b1, WORD_BYTES, 1'b0, 1'b0));
		send_word(make_word(1'b0, WORD_BYTES, 1'b0, 1'b0));
		send_word(make_word(1'b0, WORD_BYTES, 1'b0, 1'b0));
		// partial word not flagged last, then an empty remainder
		send_word(make_word(1'b1, 4'd3, 1'b0, 1'b1));
		send_word(make_word(1'b0, 4'd0, 1'b0, 1'b1));
		send_word(make_word(1'b1, WORD_BYTES, 1'b0, 1'b0));
		send_word(make_word(1'b1, 4'd12, 1'b1, 1'b0));
		// differences only beyond the valid bytes
		send_word(make_word(1'b0, 4'd5, 1'b1, 1'b1));
		// open run closed, partial region, then summary
		send_word(make_word(1'b1, WORD_BYTES, 1'b0, 1'b0));
		send_word(make_word(1'b1, 4'd7, 1'b1, 1'b0));
		send_word(make_word(1'b0, 4'd15, 1'b1, 1'b0));

		// random phases over register extremes
		run_phase(16'd64, 32'd1, 50, 1'b0);
		run_phase(16'hFFFF, 32'hFFFF_FFFF, 50, 1'b0);
		run_phase(16'd0, 32'd0, 50, 1'b1);
		run_phase(16'd16, BIG_BLOCK_BYTES, 50, 1'b0);
		run_phase(16'hFFFF, 32'd100, 40, 1'b0);
		run_phase(16'd24, BIG_BLOCK_BYTES + 32'd1, 50, 1'b1);
		run_phase(16'($urandom_range(100, 0)), $urandom, 50, 1'b0);

		settle();
		if (tracker.errors == 0 && tracker.pending.size() == 0) begin
			$display("twin_diff_dirty_region_scan_tb: clean");
		end else begin
			$display("twin_diff_dirty_region_scan_tb: errors");
		end
		$finish;
	end

endmodule
